### sv/mux_buffer_model_scheduler_defines.svh
// Assertion macros for the mux buffer model scheduler checker.
// No dependencies; the checker expects signals clk and arst_n in scope.
`ifndef MUX_BUFFER_MODEL_SCHEDULER_DEFINES_SVH
`define MUX_BUFFER_MODEL_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define MBMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbms check failed");

// next-cycle implication
`define MBMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbms check failed");

`endif

### sv/mbms_pkg.sv
// Shared types and constants of the mux buffer model scheduler.
// No dependencies; used by the top level, sequencer, datapath, checker and bench.
package mbms_pkg;

	localparam int unsigned UNIT_RING_DEPTH_DEF = 64;
	localparam int unsigned STREAM_COUNT = 2;

	localparam int unsigned TS_W   = 40;
	localparam int unsigned TICK_W = 20;
	localparam int unsigned NEED_W = 16;
	localparam int unsigned BYTE_W = 18;
	localparam int unsigned PROD_W = TICK_W + BYTE_W;
	localparam int unsigned CFG_DW = 64;
	localparam int unsigned CFG_AW = 6;

	localparam logic [TS_W-1:0] TS_CEIL   = {TS_W{1'b1}};
	localparam logic [TS_W-1:0] BEST_INIT = TS_CEIL >> 1;

	localparam logic [TICK_W-1:0] VFT_RST   = TICK_W'(3600);
	localparam logic [TICK_W-1:0] AFT_RST   = TICK_W'(2160);
	localparam logic [NEED_W-1:0] VNEED_RST = NEED_W'(2294);
	localparam logic [NEED_W-1:0] ANEED_RST = NEED_W'(2299);
	localparam logic [BYTE_W-1:0] VBUF_RST  = BYTE_W'(40960);
	localparam logic [BYTE_W-1:0] ABUF_RST  = BYTE_W'(4096);
	localparam logic [TS_W-1:0]   SDLY_RST  = TS_W'(36000);

	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_PAY   = 2'd1,
		OP_SCHED = 2'd2,
		OP_END   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RING_FULL = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		REG_VFT   = 3'd0,
		REG_AFT   = 3'd1,
		REG_VNEED = 3'd2,
		REG_ANEED = 3'd3,
		REG_VBUF  = 3'd4,
		REG_ABUF  = 3'd5,
		REG_SDLY  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		RD_WP    = 2'd0,
		RD_NEXT  = 2'd1,
		RD_NEXT2 = 2'd2
	} rd_mode_t;

	typedef struct packed {
		logic     cap;
		logic     dec_end;
		logic     set_full;
		logic     div_start;
		logic     frame_commit;
		logic     pay_apply;
		logic     sched_init;
		logic     mul;
		logic     take_best;
		logic     rel_apply;
		logic     pick;
		logic     next_t;
		logic     res_load;
		rd_mode_t rd_mode;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic open_sel;
		logic full_sel;
		logic div_done;
		logic ge_best;
		logic rel_stop;
		logic t_last;
	} sts_t;

endpackage

### sv/mbms_if.sv
// Handshake channels of the scheduler: item request and result response.
// Depends on nothing; payload widths follow the item fields.
interface mbms_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic        stream_sel;
	logic [17:0] byte_count;
	logic [39:0] clock_ref;

	modport source (output valid, op, stream_sel, byte_count, clock_ref, input ready);
	modport sink (input valid, op, stream_sel, byte_count, clock_ref, output ready);
endinterface

interface mbms_rsp_if;
	logic       valid;
	logic       ready;
	logic       chosen;
	logic       found;
	logic [1:0] status;

	modport source (output valid, chosen, found, status, input ready);
	modport sink (input valid, chosen, found, status, output ready);
endinterface

### sv/mux_buffer_model_scheduler.sv
// A frame start waits for the quotient unit; payload, end of stream and ignored frame
// starts do not; a schedule word walks both streams and each released unit. One word at a
// time; the next word is taken the cycle after the result registers. Unit release walks
// the ring one entry per cycle.
// Reset (arst_n low, asynchronous) restores config, pointers and buffer model;
// the unit ring memory is not cleared.
module mux_buffer_model_scheduler #(
	parameter int unsigned UNIT_RING_DEPTH = mbms_pkg::UNIT_RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	mbms_req_if.sink                            req,
	mbms_rsp_if.source                          rsp,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mbms_pkg::CFG_AW-1:0]         paddr,
	input  logic [mbms_pkg::CFG_DW-1:0]         pwdata,
	output logic [mbms_pkg::CFG_DW-1:0]         prdata,
	output logic                                pready
);
	import mbms_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	mbms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mbms_dp #(
		.UNIT_RING_DEPTH (UNIT_RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_op    (req.op),
		.req_sel   (req.stream_sel),
		.req_count (req.byte_count),
		.req_scr   (req.clock_ref),
		.chosen    (rsp.chosen),
		.found     (rsp.found),
		.status    (rsp.status),
		.cfg_we    (cfg_we),
		.cfg_idx   (paddr[5:3]),
		.cfg_wdata (pwdata),
		.cfg_rdata (prdata)
	);

endmodule

### sv/mbms_ctrl.sv
// Sequencer of the scheduler: decodes each word, then by its kind walks it through divide,
// payload update, or schedule compare and unit release. Depends on mbms_pkg.
module mbms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mbms_pkg::cmd_t cmd,
	input  mbms_pkg::sts_t sts
);
	import mbms_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_DIV, S_PAY, S_MUL, S_CMP, S_REL, S_PICK, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.op)
					OP_FRAME: begin
						priority if (sts.cnt_zero) begin
							cmd.dec_end = 1'b1;
							state_d     = S_FIN;
						end else if (sts.open_sel) begin
							state_d = S_FIN;
						end else if (sts.full_sel) begin
							cmd.set_full = 1'b1;
							state_d      = S_FIN;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					OP_PAY: begin
						if (sts.open_sel) begin
							cmd.rd_mode = RD_WP;
							state_d     = S_PAY;
						end else begin
							state_d = S_FIN;
						end
					end
					OP_SCHED: begin
						cmd.sched_init = 1'b1;
						state_d        = S_MUL;
					end
					OP_END: begin
						cmd.dec_end = 1'b1;
						state_d     = S_FIN;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.frame_commit = 1'b1;
					state_d          = S_FIN;
				end
			end
			S_PAY: begin
				cmd.pay_apply = 1'b1;
				state_d       = S_FIN;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.ge_best) begin
					if (sts.t_last) begin
						state_d = S_FIN;
					end else begin
						cmd.next_t = 1'b1;
						state_d    = S_MUL;
					end
				end else begin
					cmd.take_best = 1'b1;
					cmd.rd_mode   = RD_NEXT;
					state_d       = S_REL;
				end
			end
			S_REL: begin
				if (sts.rel_stop) begin
					state_d = S_PICK;
				end else begin
					cmd.rel_apply = 1'b1;
					cmd.rd_mode   = RD_NEXT2;
				end
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				if (sts.t_last) begin
					state_d = S_FIN;
				end else begin
					cmd.next_t = 1'b1;
					state_d    = S_MUL;
				end
			end
			S_FIN: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### sv/mbms_dp.sv
// Datapath of the scheduler: config registers, per-stream buffer model,
// unit ring memory, quotient unit and multiplier. Depends on mbms_pkg.
module mbms_dp #(
	parameter int unsigned UNIT_RING_DEPTH = mbms_pkg::UNIT_RING_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mbms_pkg::cmd_t              cmd,
	output mbms_pkg::sts_t              sts,
	input  logic [1:0]                  req_op,
	input  logic                        req_sel,
	input  logic [mbms_pkg::BYTE_W-1:0] req_count,
	input  logic [mbms_pkg::TS_W-1:0]   req_scr,
	output logic                        chosen,
	output logic                        found,
	output logic [1:0]                  status,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_idx,
	input  logic [mbms_pkg::CFG_DW-1:0] cfg_wdata,
	output logic [mbms_pkg::CFG_DW-1:0] cfg_rdata
);
	import mbms_pkg::*;

	localparam int unsigned PW    = $clog2(UNIT_RING_DEPTH);
	localparam int unsigned AW    = PW + 1;
	localparam int unsigned MEM_W = TS_W + BYTE_W;
	localparam int unsigned DCW   = $clog2(TICK_W + 1);

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(UNIT_RING_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
			input logic [TS_W-1:0] b);
		logic [TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TS_W] ? TS_CEIL : s[TS_W-1:0];
	endfunction

	// captured word
	op_t               op_q;
	logic              sel_q;
	logic [BYTE_W-1:0] cnt_q;
	logic [TS_W-1:0]   scr_q;

	// config
	logic [TICK_W-1:0] vft_q, aft_q;
	logic [NEED_W-1:0] vneed_q, aneed_q;
	logic [BYTE_W-1:0] vbuf_q, abuf_q;
	logic [TS_W-1:0]   sdly_q;

	// buffer model per stream
	logic [TS_W-1:0]   dt_q    [STREAM_COUNT];
	logic [TICK_W-1:0] tpb_q   [STREAM_COUNT];
	logic [BYTE_W-1:0] taken_q [STREAM_COUNT];
	logic [BYTE_W-1:0] left_q  [STREAM_COUNT];
	logic              open_q  [STREAM_COUNT];
	logic [PW-1:0]     rp_q    [STREAM_COUNT];
	logic [PW-1:0]     wp_q    [STREAM_COUNT];
	logic [BYTE_W-1:0] free_q  [STREAM_COUNT];

	// schedule walk
	logic              t_q;
	logic [TS_W-1:0]   best_q;
	logic [PROD_W-1:0] prod_s1;

	// results
	logic    chosen_w_q, found_w_q;
	status_t status_w_q;
	logic    chosen_q, found_q;
	logic [1:0] status_q;

	// quotient unit
	logic [TICK_W-1:0] div_num_q;
	logic [BYTE_W-1:0] div_rem_q;
	logic [DCW-1:0]    div_cnt_q;
	logic [BYTE_W:0]   div_try;
	logic              div_bit;

	// unit ring
	logic [MEM_W-1:0] mem [2**AW];
	logic [MEM_W-1:0] rd_data_q;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [MEM_W-1:0] wr_data;
	logic             mem_we;

	// derived values
	logic [TICK_W-1:0] ft_sel;
	logic [PW-1:0]     nx_t;
	logic [TS_W-1:0]   dts;
	logic [BYTE_W-1:0] pay_n;
	logic [BYTE_W-1:0] left_rest;
	logic [BYTE_W:0]   rel_sum;
	logic [BYTE_W-1:0] buf_t;
	logic [NEED_W-1:0] need_t;
	logic [TS_W-1:0]   rd_time;
	logic [BYTE_W-1:0] rd_size;

	assign ft_sel    = sel_q ? aft_q : vft_q;
	assign nx_t      = ring_next(rp_q[t_q]);
	assign dts       = open_q[t_q] ? sat_add(dt_q[t_q], {{(TS_W-PROD_W){1'b0}}, prod_s1})
			: dt_q[t_q];
	assign pay_n     = (cnt_q < left_q[sel_q]) ? cnt_q : left_q[sel_q];
	assign left_rest = left_q[sel_q] - pay_n;
	assign rd_time   = rd_data_q[MEM_W-1:BYTE_W];
	assign rd_size   = rd_data_q[BYTE_W-1:0];
	assign buf_t     = t_q ? abuf_q : vbuf_q;
	assign need_t    = t_q ? aneed_q : vneed_q;
	assign rel_sum   = {1'b0, free_q[t_q]} + {1'b0, rd_size};

	assign div_try = {div_rem_q, div_num_q[TICK_W-1]};
	assign div_bit = (div_try >= {1'b0, cnt_q});

	always_comb begin
		sts.op       = op_q;
		sts.cnt_zero = (cnt_q == '0);
		sts.open_sel = open_q[sel_q];
		sts.full_sel = (wp_q[sel_q] == rp_q[sel_q]);
		sts.div_done = (div_cnt_q == '0);
		sts.ge_best  = (dts >= best_q);
		sts.rel_stop = (nx_t == wp_q[t_q]) || (rd_time >= scr_q);
		sts.t_last   = t_q;
	end

	always_comb begin
		unique case (cmd.rd_mode)
			RD_WP:    rd_addr = {sel_q, wp_q[sel_q]};
			RD_NEXT:  rd_addr = {t_q, nx_t};
			RD_NEXT2: rd_addr = {t_q, ring_next(nx_t)};
			default:  rd_addr = {t_q, nx_t};
		endcase
	end

	always_comb begin
		wr_addr = {sel_q, wp_q[sel_q]};
		mem_we  = cmd.frame_commit || cmd.pay_apply;
		if (cmd.frame_commit)
			wr_data = {dt_q[sel_q], {BYTE_W{1'b0}}};
		else
			wr_data = {rd_time, rd_size + pay_n};
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_data_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= op_t'(req_op);
			sel_q <= req_sel;
			cnt_q <= req_count;
			scr_q <= req_scr;
		end
		if (cmd.mul)
			prod_s1 <= taken_q[t_q] * tpb_q[t_q];
		if (cmd.res_load) begin
			chosen_q <= chosen_w_q;
			found_q  <= found_w_q;
			status_q <= status_w_q;
		end
	end

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= DCW'(TICK_W);
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_num_q <= ft_sel;
			div_rem_q <= '0;
		end else if (div_cnt_q != '0) begin
			div_num_q <= {div_num_q[TICK_W-2:0], div_bit};
			div_rem_q <= div_bit ? BYTE_W'(div_try - {1'b0, cnt_q}) : div_try[BYTE_W-1:0];
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vft_q   <= VFT_RST;
			aft_q   <= AFT_RST;
			vneed_q <= VNEED_RST;
			aneed_q <= ANEED_RST;
			vbuf_q  <= VBUF_RST;
			abuf_q  <= ABUF_RST;
			sdly_q  <= SDLY_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_VFT:   vft_q   <= cfg_wdata[TICK_W-1:0];
				REG_AFT:   aft_q   <= cfg_wdata[TICK_W-1:0];
				REG_VNEED: vneed_q <= cfg_wdata[NEED_W-1:0];
				REG_ANEED: aneed_q <= cfg_wdata[NEED_W-1:0];
				REG_VBUF:  vbuf_q  <= cfg_wdata[BYTE_W-1:0];
				REG_ABUF:  abuf_q  <= cfg_wdata[BYTE_W-1:0];
				REG_SDLY:  sdly_q  <= cfg_wdata[TS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(cfg_idx))
			REG_VFT:   cfg_rdata = CFG_DW'(vft_q);
			REG_AFT:   cfg_rdata = CFG_DW'(aft_q);
			REG_VNEED: cfg_rdata = CFG_DW'(vneed_q);
			REG_ANEED: cfg_rdata = CFG_DW'(aneed_q);
			REG_VBUF:  cfg_rdata = CFG_DW'(vbuf_q);
			REG_ABUF:  cfg_rdata = CFG_DW'(abuf_q);
			REG_SDLY:  cfg_rdata = CFG_DW'(sdly_q);
			default:   cfg_rdata = '0;
		endcase
	end

	// buffer model and schedule state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < STREAM_COUNT; s++) begin
				dt_q[s]    <= SDLY_RST;
				tpb_q[s]   <= '0;
				taken_q[s] <= '0;
				left_q[s]  <= '0;
				open_q[s]  <= 1'b0;
				rp_q[s]    <= '0;
				wp_q[s]    <= PW'(1);
			end
			free_q[0]  <= VBUF_RST;
			free_q[1]  <= ABUF_RST;
			t_q        <= 1'b0;
			best_q     <= BEST_INIT;
			chosen_w_q <= 1'b0;
			found_w_q  <= 1'b0;
			status_w_q <= ST_OK;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_idx) == REG_VBUF)
					free_q[0] <= cfg_wdata[BYTE_W-1:0];
				if (reg_idx_t'(cfg_idx) == REG_ABUF)
					free_q[1] <= cfg_wdata[BYTE_W-1:0];
				if (reg_idx_t'(cfg_idx) == REG_SDLY) begin
					dt_q[0] <= cfg_wdata[TS_W-1:0];
					dt_q[1] <= cfg_wdata[TS_W-1:0];
				end
			end
			if (cmd.cap) begin
				chosen_w_q <= 1'b0;
				found_w_q  <= 1'b0;
				status_w_q <= ST_OK;
			end
			if (cmd.dec_end) begin
				dt_q[sel_q]    <= TS_CEIL;
				left_q[sel_q]  <= '0;
				taken_q[sel_q] <= '0;
				open_q[sel_q]  <= 1'b0;
			end
			if (cmd.set_full)
				status_w_q <= ST_RING_FULL;
			if (cmd.frame_commit) begin
				left_q[sel_q]  <= cnt_q;
				taken_q[sel_q] <= '0;
				tpb_q[sel_q]   <= div_num_q;
				open_q[sel_q]  <= 1'b1;
			end
			if (cmd.pay_apply) begin
				if (pay_n > free_q[sel_q]) begin
					status_w_q    <= ST_UNDERFLOW;
					free_q[sel_q] <= '0;
				end else begin
					free_q[sel_q] <= free_q[sel_q] - pay_n;
				end
				left_q[sel_q] <= left_rest;
				if (left_rest == '0) begin
					// last byte of the frame: commit the unit
					open_q[sel_q]  <= 1'b0;
					taken_q[sel_q] <= '0;
					wp_q[sel_q]    <= ring_next(wp_q[sel_q]);
					dt_q[sel_q]    <= sat_add(dt_q[sel_q], {{(TS_W-TICK_W){1'b0}}, ft_sel});
				end else begin
					taken_q[sel_q] <= taken_q[sel_q] + pay_n;
				end
			end
			if (cmd.sched_init) begin
				t_q    <= 1'b0;
				best_q <= BEST_INIT;
			end
			if (cmd.take_best)
				best_q <= dts;
			if (cmd.rel_apply) begin
				free_q[t_q] <= (rel_sum > {1'b0, buf_t}) ? buf_t : rel_sum[BYTE_W-1:0];
				rp_q[t_q]   <= nx_t;
			end
			if (cmd.pick && (free_q[t_q] >= BYTE_W'(need_t))) begin
				chosen_w_q <= t_q;
				found_w_q  <= 1'b1;
			end
			if (cmd.next_t)
				t_q <= 1'b1;
		end
	end

	assign chosen = chosen_q;
	assign found  = found_q;
	assign status = status_q;

endmodule

### sv/mbms_checker.sv
// Port-level checks of the scheduler, bound to the top level.
// Depends on mbms_pkg and mux_buffer_model_scheduler_defines.svh.
module mbms_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       chosen,
	input logic       found,
	input logic [1:0] status
);
	import mbms_pkg::*;
	`include "mux_buffer_model_scheduler_defines.svh"

	// one word in flight
	`MBMS_ASSERT_NEXT(a_one_word, req_valid && req_ready, !req_ready)
	`MBMS_ASSERT_NOW(a_pad_zero, rsp_valid && !found, !chosen)
	`MBMS_ASSERT_NOW(a_status_code, rsp_valid, status <= ST_UNDERFLOW)
	`MBMS_ASSERT_NOW(a_err_no_pick, rsp_valid && (status != ST_OK), !found)
	`MBMS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
		rsp_valid && $stable(chosen) && $stable(found) && $stable(status))

endmodule

bind mux_buffer_model_scheduler mbms_checker u_mbms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.chosen    (rsp.chosen),
	.found     (rsp.found),
	.status    (rsp.status)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for mux_buffer_model_scheduler: directed words, then random phases.
// Depends on mbms_pkg, mbms_req_if / mbms_rsp_if and the block itself.
module tb_top;
	import mbms_pkg::*;

	localparam int RING = UNIT_RING_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		op_t         op;
		bit          sel;
		bit [17:0]   cnt;
		bit [39:0]   scr;
	} word_t;

	typedef struct {
		bit      chosen;
		bit      found;
		status_t st;
	} pick_t;

	typedef struct {
		op_t       op;
		bit        sel;
		bit [17:0] cnt;
		bit [39:0] scr;
		bit        typed;
		bit        chosen;
		bit        found;
		status_t   st;
	} row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	mbms_req_if req_ch();
	mbms_rsp_if rsp_ch();

	mux_buffer_model_scheduler dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// shadow of the buffer model
	bit [19:0] frm_ticks[2];
	bit [15:0] need_bytes[2];
	bit [17:0] buf_bytes[2];
	bit [39:0] dly_ticks;
	bit [39:0] dec_time[2];
	bit [19:0] tick_per_byte[2];
	bit [17:0] taken[2];
	bit [17:0] left[2];
	bit        open_frm[2];
	bit [39:0] au_time[2][RING];
	bit [17:0] au_size[2][RING];
	int        rd_ptr[2];
	int        wr_ptr[2];
	bit [17:0] free_bytes[2];

	pick_t pending_results[$];
	int    mismatches = 0;
	int    words_sent = 0;
	int    picks_seen = 0;
	int    full_seen = 0;
	int    under_seen = 0;
	int    idle_cycles = 0;
	bit    gaps_on = 1;
	bit    stall_on = 1;
	bit [40:0] scr_now;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic bit [39:0] sat_add(bit [39:0] a, bit [39:0] b);
		bit [40:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[40] ? TS_CEIL : sum[39:0];
	endfunction

	function automatic int ring_step(int p);
		return (p + 1 >= RING) ? 0 : p + 1;
	endfunction

	function automatic void drop_stream(bit s);
		dec_time[s] = TS_CEIL;
		left[s] = '0;
		taken[s] = '0;
		open_frm[s] = 1'b0;
	endfunction

	function automatic void model_reset();
		frm_ticks = '{VFT_RST, AFT_RST};
		need_bytes = '{VNEED_RST, ANEED_RST};
		buf_bytes = '{VBUF_RST, ABUF_RST};
		dly_ticks = SDLY_RST;
		for (int s = 0; s < 2; s++) begin
			dec_time[s] = dly_ticks;
			tick_per_byte[s] = '0;
			taken[s] = '0;
			left[s] = '0;
			open_frm[s] = 1'b0;
			rd_ptr[s] = 0;
			wr_ptr[s] = 1 % RING;
			free_bytes[s] = buf_bytes[s];
		end
	endfunction

	function automatic void model_config(reg_idx_t idx, bit [63:0] v);
		case (idx)
			REG_VFT: frm_ticks[0] = v[19:0];
			REG_AFT: frm_ticks[1] = v[19:0];
			REG_VNEED: need_bytes[0] = v[15:0];
			REG_ANEED: need_bytes[1] = v[15:0];
			REG_VBUF: begin
				buf_bytes[0] = v[17:0];
				free_bytes[0] = v[17:0];
			end
			REG_ABUF: begin
				buf_bytes[1] = v[17:0];
				free_bytes[1] = v[17:0];
			end
			REG_SDLY: begin
				dly_ticks = v[39:0];
				dec_time[0] = v[39:0];
				dec_time[1] = v[39:0];
			end
			default: ;
		endcase
	endfunction

	function automatic pick_t buffer_model_step(word_t w);
		pick_t r;
		bit s;
		bit [17:0] n;
		bit [39:0] best, dts;
		bit [37:0] prod;
		bit [18:0] fs;
		int nx;
		r = '{1'b0, 1'b0, ST_OK};
		s = w.sel;
		case (w.op)
			OP_FRAME: begin
				if (w.cnt == 0)
					drop_stream(s);
				else if (!open_frm[s]) begin
					if (wr_ptr[s] == rd_ptr[s])
						r.st = ST_RING_FULL;
					else begin
						left[s] = w.cnt;
						taken[s] = '0;
						tick_per_byte[s] = frm_ticks[s] / w.cnt;
						au_time[s][wr_ptr[s]] = dec_time[s];
						au_size[s][wr_ptr[s]] = '0;
						open_frm[s] = 1'b1;
					end
				end
			end
			OP_PAY: begin
				if (open_frm[s]) begin
					n = (w.cnt < left[s]) ? w.cnt : left[s];
					au_size[s][wr_ptr[s]] += n;
					if (n > free_bytes[s]) begin
						r.st = ST_UNDERFLOW;
						free_bytes[s] = '0;
					end else
						free_bytes[s] -= n;
					taken[s] += n;
					left[s] -= n;
					if (left[s] == 0) begin
						open_frm[s] = 1'b0;
						taken[s] = '0;
						wr_ptr[s] = ring_step(wr_ptr[s]);
						dec_time[s] = sat_add(dec_time[s], 40'(frm_ticks[s]));
					end
				end
			end
			OP_SCHED: begin
				best = BEST_INIT;
				for (int t = 0; t < 2; t++) begin
					dts = dec_time[t];
					if (open_frm[t]) begin
						prod = taken[t] * tick_per_byte[t];
						dts = sat_add(dts, 40'(prod));
					end
					if (dts >= best)
						continue;
					best = dts;
					forever begin
						nx = ring_step(rd_ptr[t]);
						if (nx == wr_ptr[t] || au_time[t][nx] >= w.scr)
							break;
						fs = {1'b0, free_bytes[t]} + {1'b0, au_size[t][nx]};
						free_bytes[t] = (fs > {1'b0, buf_bytes[t]}) ? buf_bytes[t] : fs[17:0];
						rd_ptr[t] = nx;
					end
					if (free_bytes[t] < need_bytes[t])
						continue;
					r.chosen = t[0];
					r.found = 1'b1;
				end
			end
			default: drop_stream(s);
		endcase
		return r;
	endfunction

	task automatic apb_write(reg_idx_t idx, bit [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(idx) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		model_config(idx, v);
	endtask

	task automatic send_word(word_t w, bit use_typed, pick_t typed);
		int gap;
		pick_t p;
		gap = gaps_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= w.op;
		req_ch.stream_sel <= w.sel;
		req_ch.byte_count <= w.cnt;
		req_ch.clock_ref <= w.scr;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		p = buffer_model_step(w);
		pending_results.push_back(use_typed ? typed : p);
		words_sent++;
	endtask

	// hold off until every word has been answered, block idle
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic word_t random_word();
		word_t w;
		int r, q;
		bit [17:0] lim;
		r = $urandom_range(0, 99);
		q = $urandom_range(0, 99);
		w.sel = 1'($urandom_range(0, 1));
		w.cnt = '0;
		w.scr = scr_now[40] ? TS_CEIL : scr_now[39:0];
		if (r < 8) begin
			w.op = op_t'($urandom_range(0, 3));
			w.cnt = 18'($urandom);
			w.scr = {8'($urandom), 32'($urandom)};
		end else if (r < 36) begin
			w.op = OP_FRAME;
			w.cnt = (q < 3) ? 18'd0 : (q < 6) ? 18'h3FFFF : 18'($urandom_range(1, 3000));
		end else if (r < 70) begin
			w.op = OP_PAY;
			if (open_frm[w.sel] && q < 85) begin
				lim = (left[w.sel] < 1500) ? left[w.sel] : 18'd1500;
				w.cnt = (q < 35) ? left[w.sel] : 18'($urandom_range(1, lim));
			end else
				w.cnt = 18'($urandom);
		end else if (r < 98) begin
			w.op = OP_SCHED;
			scr_now += $urandom_range(0, 4000);
			w.scr = (q < 8) ? {8'($urandom), 32'($urandom)} :
				(scr_now[40] ? TS_CEIL : scr_now[39:0]);
		end else
			w.op = OP_END;
		return w;
	endfunction

	task automatic load_config(bit [63:0] v[7]);
		for (int i = 0; i < 7; i++)
			apb_write(reg_idx_t'(i), v[i]);
	endtask

	// response side: random stall before each word, checks in order
	initial begin
		int stall;
		pick_t e;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = stall_on ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word chosen=%0d found=%0d status=%0d",
						rsp_ch.chosen, rsp_ch.found, rsp_ch.status);
			end else begin
				e = pending_results.pop_front();
				if (rsp_ch.chosen !== e.chosen || rsp_ch.found !== e.found ||
					rsp_ch.status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp chosen=%0d found=%0d status=%0d, got %0d %0d %0d",
							e.chosen, e.found, e.st, rsp_ch.chosen, rsp_ch.found,
							rsp_ch.status);
				end
				if (e.found) picks_seen++;
				if (e.st == ST_RING_FULL) full_seen++;
				if (e.st == ST_UNDERFLOW) under_seen++;
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress, %0d results outstanding",
				pending_results.size());
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		row_t dir_rows[14];
		bit [63:0] cfg[7];
		word_t w;
		pick_t typed;
		dir_rows = '{
			'{OP_SCHED, 0, 18'd0,      40'd0,          1, 0, 1, ST_OK},
			'{OP_PAY,   0, 18'd5,      40'd0,          1, 0, 0, ST_OK},
			'{OP_FRAME, 1, 18'h3FFFF,  40'd0,          1, 0, 0, ST_OK},
			'{OP_FRAME, 1, 18'd10,     40'd0,          1, 0, 0, ST_OK},
			'{OP_PAY,   1, 18'd5000,   40'd0,          1, 0, 0, ST_UNDERFLOW},
			'{OP_PAY,   1, 18'h3FFFF,  40'd0,          1, 0, 0, ST_UNDERFLOW},
			'{OP_SCHED, 0, 18'd0,      40'd0,          0, 0, 0, ST_OK},
			'{OP_SCHED, 0, 18'd0,      TS_CEIL,        0, 0, 0, ST_OK},
			'{OP_FRAME, 0, 18'd1,      40'd0,          0, 0, 0, ST_OK},
			'{OP_PAY,   0, 18'd0,      40'd0,          0, 0, 0, ST_OK},
			'{OP_PAY,   0, 18'd1,      40'd0,          0, 0, 0, ST_OK},
			'{OP_END,   0, 18'd0,      40'd0,          1, 0, 0, ST_OK},
			'{OP_SCHED, 0, 18'd0,      TS_CEIL,        0, 0, 0, ST_OK},
			'{OP_FRAME, 1, 18'd0,      40'd0,          1, 0, 0, ST_OK}
		};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_FRAME;
		req_ch.stream_sel = 1'b0;
		req_ch.byte_count = '0;
		req_ch.clock_ref = '0;
		model_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			w = '{dir_rows[i].op, dir_rows[i].sel, dir_rows[i].cnt, dir_rows[i].scr};
			typed = '{dir_rows[i].chosen, dir_rows[i].found, dir_rows[i].st};
			send_word(w, dir_rows[i].typed, typed);
		end
		// both streams ended: nothing left to pick
		w = '{OP_SCHED, 0, 18'd0, 40'd12345};
		send_word(w, 1, '{0, 0, ST_OK});
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: cfg = '{1, 1, 1, 1, 1, 1, 0};
				1: cfg = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 18'h3FFFF, 18'h3FFFF, 0};
				2: cfg = '{VFT_RST, AFT_RST, VNEED_RST, ANEED_RST, VBUF_RST, ABUF_RST,
					SDLY_RST};
				3: cfg = '{3600, 2160, 2294, 2299, 40960, 4096, TS_CEIL};
				default: cfg = '{$urandom_range(1, 20000), $urandom_range(1, 20000),
					$urandom_range(1, 6000), $urandom_range(1, 6000),
					$urandom_range(1, 60000), $urandom_range(1, 60000),
					$urandom_range(0, 100000)};
			endcase
			load_config(cfg);
			gaps_on = (ph % 3 != 2);
			stall_on = (ph % 4 != 1);
			scr_now = (dly_ticks > 2000) ? {1'b0, dly_ticks} - 41'd2000 : 41'd0;
			if (ph == 2) begin
				// commit short frames without releasing any, until the ring fills
				for (int k = 0; k < RING + 4; k++) begin
					send_word('{OP_FRAME, 1'b0, 18'd1, 40'd0}, 0, typed);
					send_word('{OP_PAY, 1'b0, 18'd1, 40'd0}, 0, typed);
				end
				send_word('{OP_SCHED, 1'b0, 18'd0, TS_CEIL}, 0, typed);
			end
			for (int k = 0; k < 135; k++) begin
				send_word(random_word(), 0, typed);
				if (k == 70) drain();
			end
			drain();
		end

		$display("sent %0d words over 8 config phases; %0d picks, %0d ring-full, %0d underflow",
			words_sent, picks_seen, full_seen, under_seen);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
